>>> design/npsr_pkg.sv
package npsr_pkg;

	// fixed numbers of the 6k +/- 1 trial division scheme
	localparam int unsigned SMALLEST_PRIME = 2;
	localparam int unsigned LARGEST_SMALL_PRIME = 3;
	localparam int unsigned FIRST_DIVISOR = 5;
	localparam int unsigned DIVISOR_STEP = 6;
	localparam int unsigned PAIR_GAP = 2;

endpackage

>>> design/npsr_start_if.sv
interface npsr_start_if #(
	parameter int WIDTH = 32
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] start_value;

	modport source (output valid, output start_value, input ready);
	modport sink (input valid, input start_value, output ready);
endinterface

>>> design/npsr_prime_if.sv
interface npsr_prime_if #(
	parameter int WIDTH = 33
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] next_prime;

	modport source (output valid, output next_prime, input ready);
	modport sink (input valid, input next_prime, output ready);
endinterface

>>> design/npsr_div.sv
module npsr_div #(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder,
	output logic             done
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   trial;

	// one restoring step: shift in the next dividend bit and try to subtract
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	// control of the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits enter as dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial[WIDTH]) begin
				rem_q <= shifted[WIDTH-1:0];
			end else begin
				rem_q <= trial[WIDTH-1:0];
			end
			quo_q <= {quo_q[WIDTH-2:0], ~trial[WIDTH]};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

>>> design/next_prime_search.sv
// next_prime_search: smallest prime greater than or equal to a start value
//
// start_in (sink) carries start_value, VALUE_WIDTH bits unsigned; prime_out
// (source) carries next_prime, VALUE_WIDTH+1 bits. A beat moves on a clock
// edge with valid and ready both high. Start values 0 and 1 give 2.
// One start value is searched at a time; start_in.ready is high only while
// the search engine is idle. Candidates are tested in rising order: 2 and 3
// pass at once, even ones are dropped without a division, the rest are divided
// by 3 and then by 6k-1 and 6k+1 until the divisor exceeds the quotient.
// Every division runs on one shared restoring divider, one bit per cycle.
// Rejecting a composite ends at the first divisor that leaves no remainder;
// confirming a prime p takes about (sqrt(p)/3 + 1) divisions, so the cost
// grows with the size of the answer.
// The result goes to an output register; the next start value is accepted
// while it waits. If the receiver stalls with that register still full, the
// engine holds its finished result until the register frees.
// Reset (arst_n low) empties the output register and idles the engine.
module next_prime_search
	import npsr_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	npsr_start_if.sink   start_in,
	npsr_prime_if.source prime_out
);

	localparam int N  = VALUE_WIDTH + 1;
	localparam int DW = (N + 1) / 2 + 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOD3,
		ST_MODD,
		ST_MODD2,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [N-1:0]    cand_q;
	logic [DW-1:0]   div_d_q;
	logic            div_start_q;
	logic [N-1:0]    divisor_q;
	logic [N-1:0]    out_prime_q;
	logic            out_valid_q;
	logic [N-1:0]    quotient;
	logic [N-1:0]    remainder;
	logic            div_done;
	logic            rem_zero;
	logic            out_free;
	logic [N-1:0]    start_ext;

	// shared divider
	npsr_div #(
		.WIDTH(N)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (cand_q),
		.divisor  (divisor_q),
		.quotient (quotient),
		.remainder(remainder),
		.done     (div_done)
	);

	assign rem_zero  = (remainder == '0);
	assign out_free  = !out_valid_q || prime_out.ready;
	assign start_ext = {1'b0, start_in.start_value};

	assign start_in.ready       = (state_q == ST_IDLE);
	assign prime_out.valid      = out_valid_q;
	assign prime_out.next_prime = out_prime_q;

	// search sequencer with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			cand_q      <= '0;
			div_d_q     <= '0;
			divisor_q   <= '0;
			out_prime_q <= '0;
		end else begin
			// output register: load a finished search, drop a taken beat
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (prime_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					div_start_q <= 1'b0;
					if (start_in.valid) begin
						if (start_ext < N'(SMALLEST_PRIME)) begin
							cand_q <= N'(SMALLEST_PRIME);
						end else begin
							cand_q <= start_ext;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					priority if (cand_q <= N'(LARGEST_SMALL_PRIME)) begin
						div_start_q <= 1'b0;
						state_q     <= ST_FINISH;
					end else if (!cand_q[0]) begin
						div_start_q <= 1'b0;
						cand_q      <= cand_q + 1'b1;
					end else begin
						divisor_q   <= N'(LARGEST_SMALL_PRIME);
						div_start_q <= 1'b1;
						state_q     <= ST_MOD3;
					end
				end
				ST_MOD3: begin
					if (div_done) begin
						if (rem_zero) begin
							div_start_q <= 1'b0;
							cand_q      <= cand_q + 1'b1;
							state_q     <= ST_CHECK;
						end else begin
							div_d_q     <= DW'(FIRST_DIVISOR);
							divisor_q   <= N'(FIRST_DIVISOR);
							div_start_q <= 1'b1;
							state_q     <= ST_MODD;
						end
					end else begin
						div_start_q <= 1'b0;
					end
				end
				ST_MODD: begin
					if (div_done) begin
						priority if (N'(div_d_q) > quotient) begin
							div_start_q <= 1'b0;
							state_q     <= ST_FINISH;
						end else if (rem_zero) begin
							div_start_q <= 1'b0;
							cand_q      <= cand_q + 1'b1;
							state_q     <= ST_CHECK;
						end else begin
							divisor_q   <= N'(div_d_q) + N'(PAIR_GAP);
							div_start_q <= 1'b1;
							state_q     <= ST_MODD2;
						end
					end else begin
						div_start_q <= 1'b0;
					end
				end
				ST_MODD2: begin
					if (div_done) begin
						if (rem_zero) begin
							div_start_q <= 1'b0;
							cand_q      <= cand_q + 1'b1;
							state_q     <= ST_CHECK;
						end else begin
							div_d_q     <= div_d_q + DW'(DIVISOR_STEP);
							divisor_q   <= N'(div_d_q) + N'(DIVISOR_STEP);
							div_start_q <= 1'b1;
							state_q     <= ST_MODD;
						end
					end else begin
						div_start_q <= 1'b0;
					end
				end
				ST_FINISH: begin
					div_start_q <= 1'b0;
					if (out_free) begin
						out_prime_q <= cand_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					div_start_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> verif/npsr_checker.sv
`timescale 1ns / 100ps

module npsr_checker
	import npsr_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	npsr_start_if       start_mon,
	npsr_prime_if       prime_mon,
	output int unsigned mismatches,
	output int unsigned awaited
);

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] start;
		logic [VALUE_WIDTH:0]   prime;
	} search_t;

	search_t     awaited_primes[$];
	int unsigned fail_count = 0;
	int unsigned outstanding = 0;

	assign mismatches = fail_count;
	assign awaited    = outstanding;

	// trial division over 6k +/- 1 divisors, in rising candidate order
	function automatic logic [VALUE_WIDTH:0] smallest_prime_from(
		input logic [VALUE_WIDTH-1:0] start
	);
		logic [63:0] cand;
		logic [63:0] d;
		bit          composite;
		bit          found;
		cand  = 64'(start);
		found = 1'b0;
		if (cand < 64'(SMALLEST_PRIME))
			cand = 64'(SMALLEST_PRIME);
		while (!found) begin
			composite = (cand > 64'(LARGEST_SMALL_PRIME)) &&
				(cand % 64'(SMALLEST_PRIME) == 0 || cand % 64'(LARGEST_SMALL_PRIME) == 0);
			for (d = 64'(FIRST_DIVISOR); !composite && d <= cand / d;
					d += 64'(DIVISOR_STEP))
				composite = (cand % d == 0) || (cand % (d + 64'(PAIR_GAP)) == 0);
			if (composite)
				cand++;
			else
				found = 1'b1;
		end
		return cand[VALUE_WIDTH:0];
	endfunction

	// predict on each start beat, compare on each prime beat
	always @(posedge clk) begin
		search_t want;
		if (arst_n) begin
			if (start_mon.valid && start_mon.ready) begin
				want.start = start_mon.start_value;
				want.prime = smallest_prime_from(start_mon.start_value);
				awaited_primes.insert(awaited_primes.size(), want);
			end
			if (prime_mon.valid && prime_mon.ready) begin
				if (awaited_primes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected next_prime beat: expected none, got %0d",
						$time, prime_mon.next_prime);
				end else begin
					want = awaited_primes.pop_front();
					if (prime_mon.next_prime !== want.prime) begin
						fail_count++;
						$display("%0t: next_prime for start %0d: expected %0d, got %0d",
							$time, want.start, want.prime, prime_mon.next_prime);
					end
				end
			end
			outstanding <= awaited_primes.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int VALUE_WIDTH = 32;
	localparam int unsigned CYCLE_LIMIT = 20_000_000;
	localparam int unsigned LONG_HOLD = 20_000;
	localparam int unsigned RANDOM_STARTS = 130;
	localparam int unsigned SETTLE_CYCLES = 50;

	// small values, gaps between primes, prime squares, field extremes
	localparam logic [VALUE_WIDTH-1:0] DIRECTED_STARTS[20] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd24, 32'd25,
		32'd35, 32'd49, 32'd90, 32'd114, 32'd121, 32'd169, 32'd1369, 32'd32767,
		32'd65535, 32'hFFFF_FFFF
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned mismatches;
	int unsigned awaited;
	bit          steady = 1'b0;
	bit          hold_requested = 1'b0;

	npsr_start_if #(.WIDTH(VALUE_WIDTH))     start_ch ();
	npsr_prime_if #(.WIDTH(VALUE_WIDTH + 1)) prime_ch ();

	next_prime_search #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_in  (start_ch.sink),
		.prime_out (prime_ch.source)
	);

	npsr_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_mon  (start_ch),
		.prime_mon  (prime_ch),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("next_prime_search test failed");
			$finish;
		end
	end

	// idle length: mostly short, a few long, none in steady stretches
	function automatic int unsigned idle_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 300);
	endfunction

	// mostly small starts so searches stay short, some perfect squares
	function automatic logic [VALUE_WIDTH-1:0] random_start();
		int unsigned pick;
		int unsigned root;
		int unsigned bits;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			root = $urandom_range(2, 300);
			return VALUE_WIDTH'(root * root);
		end
		if (pick < 80)
			bits = $urandom_range(1, 12);
		else if (pick < 96)
			bits = $urandom_range(13, 18);
		else
			bits = $urandom_range(19, 22);
		return VALUE_WIDTH'($urandom & ((32'd1 << bits) - 1));
	endfunction

	task automatic offer_start(input logic [VALUE_WIDTH-1:0] value);
		int unsigned gap;
		gap = idle_length();
		if (gap > 0) begin
			start_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_ch.valid       <= 1'b1;
		start_ch.start_value <= value;
		do @(posedge clk); while (!start_ch.ready);
	endtask

	task automatic wait_for_primes();
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, one long hold on request
	initial begin
		int unsigned stall;
		prime_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_length();
			if (hold_requested) begin
				hold_requested = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				prime_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			prime_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// sender and verdict
	initial begin
		start_ch.valid       <= 1'b0;
		start_ch.start_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// receiver holds off while directed starts pile up behind it
		hold_requested = 1'b1;
		foreach (DIRECTED_STARTS[i])
			offer_start(DIRECTED_STARTS[i]);
		start_ch.valid <= 1'b0;
		wait_for_primes();

		for (int i = 0; i < RANDOM_STARTS; i++) begin
			if (i % 25 == 0)
				steady = ($urandom_range(0, 2) == 0);
			offer_start(random_start());
		end
		start_ch.valid <= 1'b0;
		wait_for_primes();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited == 0)
			$display("next_prime_search test passed");
		else
			$display("next_prime_search test failed");
		$finish;
	end

endmodule
